@@ rtl/egsa_pkg.sv @@
// ----------------------------------------------------------------------------
// egsa_pkg
// Shared types, constants and the binary32 adder steps of the gradient engine.
// ----------------------------------------------------------------------------
package egsa_pkg;

  localparam int ROWS      = 256;
  localparam int MAX_COLS  = 64;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int DEPTH     = ROWS * MAX_COLS;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

  // Operation codes.
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_ACC  = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;
  localparam logic [1:0] FUNC_BAD  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_SKIP = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_LOWER = 2'd0;
  localparam logic [1:0] REG_UPPER = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;
  localparam logic [1:0] REG_WIDTH = 2'd3;

  // Aligned operands handed from the alignment step to the add step.
  typedef struct packed {
    logic        special;   // result fixed by NaN or infinity
    logic [31:0] spec_val;
    logic        sign_a;
    logic        sign_b;
    logic [7:0]  exp;       // common exponent (biased, subnormal as 1)
    logic [26:0] man_a;     // larger operand, with guard, round and sticky
    logic [26:0] man_b;     // smaller operand, shifted, sticky folded in
    logic        both_zero_neg;
  } align_t;

  // Step one: unpack, order by magnitude and align the smaller operand.
  function automatic align_t fp_align(input logic [31:0] a, input logic [31:0] b);
    align_t      r;
    logic [31:0] big;
    logic [31:0] sml;
    logic [7:0]  eb;
    logic [7:0]  es;
    logic [23:0] mb;
    logic [23:0] ms;
    logic [7:0]  d;
    logic [50:0] ext;
    logic [50:0] sh;
    logic        a_nan;
    logic        b_nan;
    logic        a_inf;
    logic        b_inf;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    r = '0;
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
      r.special  = 1'b1;
      r.spec_val = CANON_NAN;
    end else if (a_inf) begin
      r.special  = 1'b1;
      r.spec_val = a;
    end else if (b_inf) begin
      r.special  = 1'b1;
      r.spec_val = b;
    end
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    mb = {(big[30:23] != 8'd0), big[22:0]};
    ms = {(sml[30:23] != 8'd0), sml[22:0]};
    d  = eb - es;
    ext = {ms, 27'd0};
    sh  = (d > 8'd26) ? 51'd0 : (ext >> d);
    r.sign_a = big[31];
    r.sign_b = sml[31];
    r.exp    = eb;
    r.man_a  = {mb, 3'b000};
    // Keep 26 bits and fold the rest into the sticky bit.
    if (d > 8'd26) begin
      r.man_b = {26'd0, (ms != 24'd0)};
    end else begin
      r.man_b = {sh[50:25], (sh[24:0] != 25'd0)};
    end
    r.both_zero_neg = a[31] && b[31];
    return r;
  endfunction

  // Step two: add or subtract, normalize and round to nearest even.
  function automatic logic [31:0] fp_finish(input align_t p);
    logic [27:0] sum;
    logic [27:0] m;
    logic [4:0]  lz;
    logic [9:0]  e;
    logic [9:0]  ne;
    logic [24:0] rnd;
    logic        lsb;
    logic        g;
    logic        st;
    logic [31:0] res;
    logic        sgn;
    if (p.sign_a == p.sign_b) begin
      sum = {1'b0, p.man_a} + {1'b0, p.man_b};
    end else begin
      sum = {1'b0, p.man_a} - {1'b0, p.man_b};
    end
    sgn = p.sign_a;
    e   = {2'b00, p.exp};
    m   = sum;
    lz  = 5'd0;
    if (sum == 28'd0) begin
      res = {(p.sign_a == p.sign_b) ? p.both_zero_neg : 1'b0, 31'd0};
    end else begin
      if (m[27]) begin
        m = {1'b0, m[27:2], m[1] | m[0]};
        e = e + 10'd1;
      end else begin
        // Leading-zero count over the 27-bit result.
        for (int i = 26; i >= 0; i--) begin
          if (m[i] && (lz == 5'd0) && (i != 26)) begin
            lz = 5'(26 - i);
          end
          if (m[i] && (i == 26)) begin
            lz = 5'd31;
          end
        end
        if (lz == 5'd31) begin
          lz = 5'd0;
        end
        // Do not shift below the subnormal exponent.
        if ({5'd0, lz} >= e) begin
          lz = 5'(e - 10'd1);
        end
        m = m << lz;
        e = e - {5'd0, lz};
      end
      lsb = m[3];
      g   = m[2];
      st  = m[1] | m[0];
      rnd = {1'b0, m[26:3]} + {24'd0, (g && (st || lsb))};
      ne  = e;
      if (rnd[24]) begin
        rnd = rnd >> 1;
        ne  = ne + 10'd1;
      end
      if (ne >= 10'd255) begin
        res = {sgn, 8'hFF, 23'd0};
      end else if (!rnd[23]) begin
        res = {sgn, 8'd0, rnd[22:0]};
      end else begin
        res = {sgn, ne[7:0], rnd[22:0]};
      end
    end
    if (p.special) begin
      res = p.spec_val;
    end
    return res;
  endfunction

endpackage

@@ rtl/egsa_if.sv @@
// ----------------------------------------------------------------------------
// egsa_if
// Valid/ready channel interfaces for items, results and configuration.
// ----------------------------------------------------------------------------
interface egsa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] row;
  logic [5:0]  col;
  logic [31:0] value;
  modport source (output valid, func, row, col, value, input ready);
  modport sink   (input valid, func, row, col, value, output ready);
endinterface

interface egsa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  logic [1:0]  status;
  modport source (output valid, data, status, input ready);
  modport sink   (input valid, data, status, output ready);
endinterface

interface egsa_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [8:0]  wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

@@ rtl/egsa_ram.sv @@
// ----------------------------------------------------------------------------
// egsa_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module egsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/embedding_grad_scatter_add_top.sv @@
// Gradient scatter-add engine: each item is a load, accumulate or read of one
// binary32 entry of a 256 x 64 table held in one synchronous RAM, and each gives
// one result. An item passes from acceptance to result through decode and RAM
// read, read data, alignment, then add and write back, and a new item can be
// accepted once the previous one has left its add step, while that result waits
// in the output register; a result held back by the receiver stalls the next
// item in its add step. The single RAM read-modify-write path and the two-step
// adder set this sequence. The RAM needs no clearing pass.
// ----------------------------------------------------------------------------
// embedding_grad_scatter_add_top
// Top level: checks, RAM sequencing, binary32 accumulate and result register.
// ----------------------------------------------------------------------------
module embedding_grad_scatter_add_top (
  input  logic clk,
  input  logic rst,
  egsa_in_if.sink    in_ch,
  egsa_out_if.source out_ch,
  egsa_cfg_if.sink   cfg
);
  import egsa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_ALIGN = 4'b0100,
    S_ADD   = 4'b1000
  } state_t;

  state_t      state;
  logic [8:0]  lower_row;
  logic [8:0]  upper_row;
  logic [8:0]  row_count;
  logic [6:0]  row_width;
  logic [1:0]  func;
  logic [31:0] value;
  logic [1:0]  pstatus;
  logic [ADDR_W-1:0] addr;
  logic [31:0] rdata;
  align_t      algn;
  logic        out_valid;
  logic [31:0] out_data;
  logic [1:0]  out_status;
  logic        in_fire;
  logic        add_go;
  logic        bad;
  logic        skip;
  logic        we;
  logic [31:0] wdata;
  logic [31:0] sum;

  assign cfg.ready   = 1'b1;
  assign in_ch.ready = (state == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  // The add step completes once the result register is free or being emptied.
  assign add_go      = (state == S_ADD) && (!out_valid || out_ch.ready);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      lower_row <= 9'd0;
      upper_row <= 9'd256;
      row_count <= 9'd256;
      row_width <= 7'd64;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_LOWER: lower_row <= cfg.wdata;
        REG_UPPER: upper_row <= cfg.wdata;
        REG_COUNT: row_count <= cfg.wdata;
        REG_WIDTH: row_width <= cfg.wdata[6:0];
        default:   lower_row <= lower_row;
      endcase
    end
  end

  // Index and window checks on the incoming item.
  always_comb begin
    bad = (in_ch.func == FUNC_BAD) || ({7'd0, in_ch.row} >= {14'd0, row_count}) ||
          (in_ch.row >= 16'(ROWS)) || ({1'b0, in_ch.col} >= row_width);
    skip = (in_ch.func == FUNC_ACC) &&
           (({7'd0, in_ch.row} < {14'd0, lower_row}) ||
            ({7'd0, in_ch.row} >= {14'd0, upper_row}));
  end

  // Table RAM: load writes on acceptance, accumulate writes back after the add.
  // The read address is held on the item's entry while it is in flight.
  assign sum   = fp_finish(algn);
  assign we    = (in_fire && !bad && (in_ch.func == FUNC_LOAD)) ||
                 (add_go && (func == FUNC_ACC) && (pstatus == ST_DONE));
  assign wdata = (state == S_ADD) ? sum : in_ch.value;

  egsa_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr((state == S_ADD) ? addr : {in_ch.row[ROW_W-1:0], in_ch.col[COL_W-1:0]}),
    .wdata(wdata),
    .raddr((state == S_IDLE) ? {in_ch.row[ROW_W-1:0], in_ch.col[COL_W-1:0]} : addr),
    .rdata(rdata)
  );

  // Item sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (add_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= S_READ;
          end
        end
        S_READ:  state <= S_ALIGN;
        S_ALIGN: state <= S_ADD;
        S_ADD: begin
          if (add_go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Item payload and arithmetic pipeline registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func    <= in_ch.func;
      value   <= in_ch.value;
      addr    <= {in_ch.row[ROW_W-1:0], in_ch.col[COL_W-1:0]};
      pstatus <= bad ? ST_ERR : (skip ? ST_SKIP : ST_DONE);
    end
    if (state == S_ALIGN) begin
      algn <= fp_align(rdata, value);
    end
    if (add_go) begin
      out_status <= pstatus;
      if (pstatus != ST_DONE) begin
        out_data <= 32'd0;
      end else begin
        case (func)
          FUNC_LOAD: out_data <= value;
          FUNC_ACC:  out_data <= sum;
          default:   out_data <= rdata;
        endcase
      end
    end
  end

  assign out_ch.valid  = out_valid;
  assign out_ch.data   = out_data;
  assign out_ch.status = out_status;

`ifndef SYNTHESIS
  // One item in flight at a time: no acceptance while busy.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ch.ready)
    else $error("item accepted while busy");
  // A result appears exactly after the add step.
  a_result_timing: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(state == S_ADD))
    else $error("result raised outside add step");
  // Error and skip results carry zero data.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_ch.status != ST_DONE)) |-> (out_ch.data == 32'd0))
    else $error("nonzero data with error status");
  // Table is written only by a good load or an accumulate write-back.
  a_write_src: assert property (@(posedge clk) disable iff (rst)
    we |-> (in_fire || ((state == S_ADD) && (pstatus == ST_DONE))))
    else $error("unexpected table write");
`endif

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the gradient scatter-add engine: loads, binary32 accumulates and reads
// are sent under random idling and stalls across several register settings, and
// each result is compared with an in-bench predictor of the table.
// ----------------------------------------------------------------------------
module testbench;
  import egsa_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] row;
    logic [5:0]  col;
    logic [31:0] value;
  } grad_op_t;

  typedef struct packed {
    logic [31:0] data;
    logic [1:0]  status;
  } entry_res_t;

  logic clk;
  logic rst;

  egsa_in_if  in_ch ();
  egsa_out_if out_ch ();
  egsa_cfg_if cfg ();

  embedding_grad_scatter_add_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  // Register copies shared by the stimulus generator and the predictor.
  int unsigned lo_row  = 0;
  int unsigned hi_row  = 256;
  int unsigned row_lim = 256;
  int unsigned col_lim = 64;

  logic [31:0] wgt_mem [DEPTH];
  bit          loaded  [DEPTH];
  int unsigned loaded_addrs[$];

  grad_op_t   pending_ops[$];
  entry_res_t expected_res[$];

  int  sent_cnt;
  int  mismatches;
  int  cycles;
  bit  calm;

  // Clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Binary32 addition, round to nearest even, subnormals kept, NaN canonical.
  function automatic logic [31:0] bin32_sum(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] big, sml;
    logic [23:0] mb, ms;
    int          eb, es, d, p, ex, sh;
    logic [63:0] wa, wb, ws, s, mant, rem, half;
    logic        sgn, up;
    bit          a_nan, b_nan, a_inf, b_inf;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 0);
    if (a_nan || b_nan || (a_inf && b_inf && a[31] != b[31])) return CANON_NAN;
    if (a_inf) return a;
    if (b_inf) return b;
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    eb = (big[30:23] == 0) ? 1 : int'(big[30:23]);
    es = (sml[30:23] == 0) ? 1 : int'(sml[30:23]);
    mb = {big[30:23] != 0, big[22:0]};
    ms = {sml[30:23] != 0, sml[22:0]};
    d  = eb - es;
    wa = {8'd0, mb, 32'd0};
    ws = {8'd0, ms, 32'd0};
    // Align the smaller operand, folding lost bits into a sticky bit.
    if (d >= 56) begin
      wb = {63'd0, ms != 0};
    end else begin
      wb = ws >> d;
      if ((ws & ((64'd1 << d) - 64'd1)) != 0) wb[0] = 1'b1;
    end
    s   = (big[31] == sml[31]) ? wa + wb : wa - wb;
    sgn = big[31];
    if (s == 0) return {big[31] & sml[31], 31'd0};
    p = 0;
    for (int i = 0; i < 64; i++) begin
      if (s[i]) p = i;
    end
    sh = p - 23;
    ex = eb - 32 + sh;
    if (ex < 1) begin
      sh = sh + 1 - ex;
      ex = 1;
    end
    // Round the dropped bits to nearest, ties to even.
    if (sh <= 0) begin
      mant = s << (-sh);
    end else begin
      mant = s >> sh;
      rem  = s & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      up   = (rem > half) || (rem == half && mant[0]);
      if (up) mant = mant + 64'd1;
    end
    if (mant == (64'd1 << 24)) begin
      mant = mant >> 1;
      ex   = ex + 1;
    end
    if (ex >= 255) return {sgn, 8'hFF, 23'd0};
    if (mant < (64'd1 << 23)) return {sgn, 8'd0, mant[22:0]};
    return {sgn, ex[7:0], mant[22:0]};
  endfunction

  // Predicts the result of one operation and updates the predicted table.
  function automatic entry_res_t predict_entry(input grad_op_t op);
    entry_res_t  r;
    int unsigned addr;
    r = '0;
    addr = op.row * MAX_COLS + op.col;
    if (op.func == FUNC_BAD || op.row >= row_lim || op.row >= ROWS ||
        op.col >= col_lim) begin
      r.status = ST_ERR;
    end else if (op.func == FUNC_LOAD) begin
      wgt_mem[addr] = op.value;
      r.data = op.value;
    end else if (op.func == FUNC_ACC) begin
      if (op.row < lo_row || op.row >= hi_row) begin
        r.status = ST_SKIP;
      end else begin
        wgt_mem[addr] = bin32_sum(wgt_mem[addr], op.value);
        r.data = wgt_mem[addr];
      end
    end else begin
      r.data = wgt_mem[addr];
    end
    return r;
  endfunction

  // Random binary32 pattern weighted toward the interesting corners.
  function automatic logic [31:0] pick_bin32();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(9))
      0: v[30:23] = 8'h00;
      1: v[30:23] = 8'hFF;
      2: v[30:0] = 31'd0;
      3: v[30:23] = 8'hFE;
      4, 5, 6: v[30:23] = 8'(124 + $urandom_range(8));
      7: v[22:0] = 23'($urandom_range(3) << 21);
      default: ;
    endcase
    return v;
  endfunction

  // Queues one operation; a read or accumulate that would touch a never
  // written entry is turned into a load of that entry.
  task automatic queue_op(input grad_op_t op);
    int unsigned addr;
    bit          valid_idx;
    bit          touches;
    addr = op.row * MAX_COLS + op.col;
    valid_idx = op.func != FUNC_BAD && op.row < row_lim && op.row < ROWS &&
                op.col < col_lim;
    touches = valid_idx && (op.func == FUNC_READ ||
              (op.func == FUNC_ACC && op.row >= lo_row && op.row < hi_row));
    if (touches && !loaded[addr]) op.func = FUNC_LOAD;
    if (valid_idx && op.func == FUNC_LOAD && !loaded[addr]) begin
      loaded[addr] = 1'b1;
      loaded_addrs.push_back(addr);
    end
    pending_ops.push_back(op);
  endtask

  task automatic queue_random(input int n);
    grad_op_t    op;
    int unsigned a;
    repeat (n) begin
      op.value = pick_bin32();
      case ($urandom_range(19))
        0:           op.func = FUNC_BAD;
        1, 2, 3, 4:  op.func = FUNC_LOAD;
        5, 6, 7:     op.func = FUNC_READ;
        default:     op.func = FUNC_ACC;
      endcase
      case ($urandom_range(9))
        0: begin
          op.row = 16'($urandom);
          op.col = 6'($urandom);
        end
        1: begin
          op.row = 16'($urandom_range(255));
          op.col = 6'($urandom);
        end
        2, 3: begin
          op.row = 16'($urandom_range(row_lim - 1));
          op.col = 6'($urandom_range(col_lim - 1));
        end
        default: begin
          if (loaded_addrs.size() > 0) begin
            a = loaded_addrs[$urandom_range(loaded_addrs.size() - 1)];
            op.row = 16'(a / MAX_COLS);
            op.col = 6'(a % MAX_COLS);
          end else begin
            op.row = 16'($urandom_range(row_lim - 1));
            op.col = 6'($urandom_range(col_lim - 1));
          end
        end
      endcase
      queue_op(op);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.wdata <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    case (idx)
      REG_LOWER: lo_row  = val;
      REG_UPPER: hi_row  = val;
      REG_COUNT: row_lim = val;
      default:   col_lim = val[6:0];
    endcase
  endtask

  task automatic set_regs(input int lo, input int hi, input int cnt, input int wid);
    write_reg(REG_LOWER, 9'(lo));
    write_reg(REG_UPPER, 9'(hi));
    write_reg(REG_COUNT, 9'(cnt));
    write_reg(REG_WIDTH, 9'(wid));
  endtask

  // Waits until no transaction is queued, offered or awaiting its result.
  task automatic drain();
    while (pending_ops.size() > 0 || expected_res.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Input driver: pops pending operations, idles in random bursts and feeds
  // the predictor on each accepted transaction.
  int       gap_left;
  grad_op_t cur_op;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_res.push_back(predict_entry(cur_op));
        sent_cnt++;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (gap_left == 0 && !calm && $urandom_range(9) == 0) begin
          gap_left = $urandom_range(9, 1);
        end
        if (gap_left > 0 || pending_ops.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_ch.valid <= 1'b0;
        end else begin
          cur_op = pending_ops.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.func  <= cur_op.func;
          in_ch.row   <= cur_op.row;
          in_ch.col   <= cur_op.col;
          in_ch.value <= cur_op.value;
        end
      end
    end
  end

  // Result side ready: random stall bursts plus one long hold-off.
  int stall_left;
  int hold_left;
  bit held;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
      held       = 1'b0;
    end else begin
      if (!held && sent_cnt >= 500) begin
        held      = 1'b1;
        hold_left = 300;
      end
      if (stall_left == 0 && !calm && $urandom_range(7) == 0) begin
        stall_left = $urandom_range(9, 1);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Result checker.
  entry_res_t want;
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result data=%h status=%0d", out_ch.data, out_ch.status);
        end
      end else begin
        want = expected_res.pop_front();
        if (want.data !== out_ch.data || want.status !== out_ch.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: expected data=%h status=%0d, got data=%h status=%0d",
                     want.data, want.status, out_ch.data, out_ch.status);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    grad_op_t op;
    clk = 1'b0;
    rst = 1'b1;
    in_ch.valid  = 1'b0;
    in_ch.func   = FUNC_LOAD;
    in_ch.row    = '0;
    in_ch.col    = '0;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    cfg.valid    = 1'b0;
    cfg.index    = REG_LOWER;
    cfg.wdata    = '0;
    sent_cnt = 0;
    mismatches = 0;
    cycles = 0;
    calm = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset settings: corner values and every operation.
    op = '{FUNC_LOAD, 16'd0, 6'd0, 32'h7F7F_FFFF};   queue_op(op);
    op = '{FUNC_ACC, 16'd0, 6'd0, 32'h7F7F_FFFF};    queue_op(op);
    op = '{FUNC_READ, 16'd0, 6'd0, 32'h0};           queue_op(op);
    op = '{FUNC_LOAD, 16'd255, 6'd63, 32'h0000_0001}; queue_op(op);
    op = '{FUNC_ACC, 16'd255, 6'd63, 32'h8000_0001}; queue_op(op);
    op = '{FUNC_ACC, 16'd255, 6'd63, 32'h8000_0000}; queue_op(op);
    op = '{FUNC_LOAD, 16'd1, 6'd1, 32'h7F80_0000};   queue_op(op);
    op = '{FUNC_ACC, 16'd1, 6'd1, 32'hFF80_0000};    queue_op(op);
    op = '{FUNC_ACC, 16'd1, 6'd1, 32'h7FFF_FFFF};    queue_op(op);
    op = '{FUNC_LOAD, 16'd2, 6'd2, 32'h3F80_0000};   queue_op(op);
    op = '{FUNC_ACC, 16'd2, 6'd2, 32'h3380_0000};    queue_op(op);
    op = '{FUNC_ACC, 16'd2, 6'd2, 32'h3400_0001};    queue_op(op);
    op = '{FUNC_ACC, 16'd2, 6'd2, 32'hBF80_0000};    queue_op(op);
    op = '{FUNC_LOAD, 16'd3, 6'd5, 32'h0080_0000};   queue_op(op);
    op = '{FUNC_ACC, 16'd3, 6'd5, 32'h8000_0001};    queue_op(op);
    op = '{FUNC_BAD, 16'd3, 6'd5, 32'hFFFF_FFFF};    queue_op(op);
    op = '{FUNC_READ, 16'hFFFF, 6'd63, 32'h0};       queue_op(op);
    op = '{FUNC_ACC, 16'd256, 6'd0, 32'h3F80_0000};  queue_op(op);
    op = '{FUNC_READ, 16'd255, 6'd63, 32'h0};        queue_op(op);
    queue_random(400);
    drain();

    // Narrow window with a partial table.
    set_regs(10, 50, 100, 20);
    queue_random(300);
    drain();

    // Empty window: every valid accumulate is skipped.
    set_regs(200, 40, 256, 64);
    queue_random(200);
    drain();

    // Smallest table.
    set_regs(0, 0, 1, 1);
    queue_random(150);
    drain();

    set_regs(255, 256, 256, 33);
    queue_random(250);
    drain();

    set_regs(256, 256, 200, 64);
    queue_random(150);
    drain();

    // Final stretch without idling on either side.
    set_regs(0, 256, 256, 64);
    calm = 1'b1;
    queue_random(350);
    drain();
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
